// ===== hw/rtl/mf3_pkg.sv =====
package mf3_pkg;

    localparam int FIELD_W = 16;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;

    localparam int MIN_DIM = 3;
    localparam int MAX_DIM = 1024;

    localparam logic [IDX_W-1:0] IDX_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] IDX_IMAGE_HEIGHT = 2'd1;

    // Per-pixel bookkeeping that travels with a sample through the pipeline.
    typedef struct packed {
        logic               emit;
        logic               done;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_meta;

endpackage

// ===== hw/rtl/mf3_line_buf.sv =====
module mf3_line_buf
    import mf3_pkg::*;
#(
    parameter int DW    = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DW-1:0]            i_pixel,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  t_meta                    i_meta,
    output logic                     o_col_valid,
    input  logic                     i_col_ready,
    output logic [DW-1:0]            o_top,
    output logic [DW-1:0]            o_mid,
    output logic [DW-1:0]            o_bot,
    output t_meta                    o_meta
);

    localparam int AW = $clog2(DEPTH);

    // Each entry holds the column's two rows above: row r-2 high, row r-1 low.
    logic [2*DW-1:0] r_mem [DEPTH];
    logic [2*DW-1:0] r_q;

    logic            r_a_valid;
    logic [DW-1:0]   r_a_pix;
    logic [AW-1:0]   r_a_addr;
    t_meta           r_a_meta;

    logic            a_go;
    logic            xfer;

    assign a_go    = r_a_valid && i_col_ready;
    assign o_ready = !r_a_valid || a_go;
    assign xfer    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_a_pix  <= i_pixel;
            r_a_addr <= i_addr;
            r_a_meta <= i_meta;
        end
    end

    // The read data stays put while the stage is stalled, because a new read
    // is issued only when the stage is empty or the held pixel leaves in the same cycle.
    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_mem[r_a_addr] <= {r_q[DW-1:0], r_a_pix};
        end
        if (xfer) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_col_valid = r_a_valid;
    assign o_top       = r_q[2*DW-1:DW];
    assign o_mid       = r_q[DW-1:0];
    assign o_bot       = r_a_pix;
    assign o_meta      = r_a_meta;

    // Consecutive pixels sit in different columns, so a write never meets a read.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && xfer) |-> (r_a_addr != i_addr))
        else $error("line store read and write hit the same column");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && !xfer) |=> !r_a_valid)
        else $error("line store stage kept a pixel that already left");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !i_col_ready) |=> (r_a_valid && $stable(r_a_addr)))
        else $error("line store stage lost a stalled pixel");

endmodule

// ===== hw/rtl/mf3_med.sv =====
module mf3_med
    import mf3_pkg::*;
#(
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_col_valid,
    output logic          o_col_ready,
    input  logic [DW-1:0] i_top,
    input  logic [DW-1:0] i_mid,
    input  logic [DW-1:0] i_bot,
    input  t_meta         i_meta,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [DW-1:0] o_median,
    output t_meta         o_meta
);

    function automatic logic [DW-1:0] max2(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [DW-1:0] min2(input logic [DW-1:0] a, input logic [DW-1:0] b);
        return (a > b) ? b : a;
    endfunction

    function automatic logic [DW-1:0] med3(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Window columns are kept sorted; index 0 is the older column.
    logic [DW-1:0] r_win_lo [2];
    logic [DW-1:0] r_win_md [2];
    logic [DW-1:0] r_win_hi [2];

    logic          r_b_valid;
    logic [DW-1:0] r_b_lo [3];
    logic [DW-1:0] r_b_md [3];
    logic [DW-1:0] r_b_hi [3];
    t_meta         r_b_meta;

    logic          r_c_valid;
    logic [DW-1:0] r_c_lo;
    logic [DW-1:0] r_c_md;
    logic [DW-1:0] r_c_hi;
    t_meta         r_c_meta;

    logic          r_o_valid;
    logic [DW-1:0] r_o_med;
    t_meta         r_o_meta;

    logic [DW-1:0] x0, x1, t;
    logic [DW-1:0] col_lo, col_md, col_hi;
    logic          col_xfer;
    logic          b_go;
    logic          c_go;

    always_comb begin
        x0     = min2(i_top, i_mid);
        x1     = max2(i_top, i_mid);
        col_hi = max2(x1, i_bot);
        t      = min2(x1, i_bot);
        col_lo = min2(x0, t);
        col_md = max2(x0, t);
    end

    assign c_go        = r_c_valid && (!r_o_valid || i_ready);
    assign b_go        = r_b_valid && (!r_c_valid || c_go);
    assign o_col_ready = !r_b_valid || b_go;
    assign col_xfer    = i_col_valid && o_col_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_col_ready) begin
                r_b_valid <= i_col_valid && i_meta.emit;
            end
            if (!r_c_valid || c_go) begin
                r_c_valid <= b_go;
            end
            if (!r_o_valid || i_ready) begin
                r_o_valid <= c_go;
            end
        end
    end

    // Every column shifts through the window, whether or not it yields a result.
    always_ff @(posedge i_clk) begin
        if (col_xfer) begin
            r_win_lo[0] <= r_win_lo[1];
            r_win_md[0] <= r_win_md[1];
            r_win_hi[0] <= r_win_hi[1];
            r_win_lo[1] <= col_lo;
            r_win_md[1] <= col_md;
            r_win_hi[1] <= col_hi;
        end
        if (col_xfer && o_col_ready) begin
            r_b_lo   <= '{r_win_lo[0], r_win_lo[1], col_lo};
            r_b_md   <= '{r_win_md[0], r_win_md[1], col_md};
            r_b_hi   <= '{r_win_hi[0], r_win_hi[1], col_hi};
            r_b_meta <= i_meta;
        end
        if (b_go) begin
            r_c_lo   <= max2(max2(r_b_lo[0], r_b_lo[1]), r_b_lo[2]);
            r_c_md   <= med3(r_b_md[0], r_b_md[1], r_b_md[2]);
            r_c_hi   <= min2(min2(r_b_hi[0], r_b_hi[1]), r_b_hi[2]);
            r_c_meta <= r_b_meta;
        end
        if (c_go) begin
            r_o_med  <= med3(r_c_lo, r_c_md, r_c_hi);
            r_o_meta <= r_c_meta;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_median = r_o_med;
    assign o_meta   = r_o_meta;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> ((r_b_lo[2] <= r_b_md[2]) && (r_b_md[2] <= r_b_hi[2])))
        else $error("newest window column is not sorted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_go |=> r_c_valid)
        else $error("median stage dropped a window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_ready) |=> (r_o_valid && $stable(r_o_med) && $stable(r_o_meta)))
        else $error("stalled result changed before its transfer");

endmodule

// ===== hw/rtl/median_filter_3x3.sv =====
// Channel | Dir | Handshake                        | Payload
// pixel   | in  | i_pixel_valid / o_pixel_ready    | i_pixel
// result  | out | o_result_valid / i_result_ready  | o_median_value, o_center_col,
//         |     |                                  | o_center_row, o_frame_done
// config  | in  | i_cfg_we, write only             | i_cfg_idx, i_cfg_data
//
// One pixel per clock while the result side accepts; a result passes through the line
// memory, window, median and output registers. The rate is set by the line memory:
// a read and a write port, each used once per pixel (read at transfer, write on exit).
// Reset is synchronous; it clears the position counters and pipeline valids and sets
// width and height to 1024. The line memory is not cleared and needs no clearing pass.
// A stall on the result side fills the output, median and window stages in turn;
// o_pixel_ready drops only when all of them and the line memory stage are occupied.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_pixel_valid,
    output logic               o_pixel_ready,
    input  logic [FIELD_W-1:0] i_pixel,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [FIELD_W-1:0] o_median_value,
    output logic [COORD_W-1:0] o_center_col,
    output logic [COORD_W-1:0] o_center_row,
    output logic               o_frame_done
);

    localparam int DW = (PIXEL_BITS < FIELD_W) ? PIXEL_BITS : FIELD_W;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CFG_W-1:0] DIM_LOW     = CFG_W'(MIN_DIM);
    localparam logic [CFG_W-1:0] HEIGHT_HIGH = CFG_W'(MAX_DIM);
    localparam logic [CFG_W-1:0] WIDTH_HIGH  =
        CFG_W'((MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM);

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        return (v < DIM_LOW) ? DIM_LOW : ((v > hi) ? hi : v);
    endfunction

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [COORD_W-1:0] r_col;
    logic [COORD_W-1:0] r_row;

    logic               lb_ready;
    logic               px_xfer;
    logic               col_over;
    logic [CFG_W-1:0]   row_adv;
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] cur_row;
    logic [CFG_W-1:0]   col_inc;
    logic [CFG_W-1:0]   row_inc;
    logic               last_col;
    logic               last_row;
    t_meta              px_meta;

    logic               col_valid;
    logic               col_ready;
    logic [DW-1:0]      col_top;
    logic [DW-1:0]      col_mid;
    logic [DW-1:0]      col_bot;
    t_meta              col_meta;
    logic [DW-1:0]      med_value;
    t_meta              med_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_HIGH;
            r_height <= HEIGHT_HIGH;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == IDX_IMAGE_WIDTH) begin
                r_width <= clamp_dim(i_cfg_data, WIDTH_HIGH);
            end else if (i_cfg_idx == IDX_IMAGE_HEIGHT) begin
                r_height <= clamp_dim(i_cfg_data, HEIGHT_HIGH);
            end
        end
    end

    // A column at or past the width (after a size change) counts as a finished row.
    always_comb begin
        col_over = {1'b0, r_col} >= r_width;
        cur_col  = col_over ? '0 : r_col;
        row_adv  = col_over ? ({1'b0, r_row} + 1'b1) : {1'b0, r_row};
        cur_row  = (row_adv >= r_height) ? '0 : row_adv[COORD_W-1:0];
        col_inc  = {1'b0, cur_col} + 1'b1;
        row_inc  = {1'b0, cur_row} + 1'b1;
        last_col = col_inc >= r_width;
        last_row = row_inc >= r_height;

        px_meta.emit = (cur_row >= COORD_W'(2)) && (cur_col >= COORD_W'(2));
        px_meta.done = last_row && last_col;
        px_meta.col  = cur_col - 1'b1;
        px_meta.row  = cur_row - 1'b1;
    end

    assign o_pixel_ready = lb_ready;
    assign px_xfer       = i_pixel_valid && lb_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (px_xfer) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : row_inc[COORD_W-1:0];
            end else begin
                r_col <= col_inc[COORD_W-1:0];
                r_row <= cur_row;
            end
        end
    end

    mf3_line_buf #(
        .DW    (DW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pixel_valid),
        .o_ready     (lb_ready),
        .i_pixel     (DW'(i_pixel)),
        .i_addr      (AW'(cur_col)),
        .i_meta      (px_meta),
        .o_col_valid (col_valid),
        .i_col_ready (col_ready),
        .o_top       (col_top),
        .o_mid       (col_mid),
        .o_bot       (col_bot),
        .o_meta      (col_meta)
    );

    mf3_med #(
        .DW (DW)
    ) u_med (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_valid (col_valid),
        .o_col_ready (col_ready),
        .i_top       (col_top),
        .i_mid       (col_mid),
        .i_bot       (col_bot),
        .i_meta      (col_meta),
        .o_valid     (o_result_valid),
        .i_ready     (i_result_ready),
        .o_median    (med_value),
        .o_meta      (med_meta)
    );

    assign o_median_value = FIELD_W'(med_value);
    assign o_center_col   = med_meta.col;
    assign o_center_row   = med_meta.row;
    assign o_frame_done   = med_meta.done;

endmodule

// ===== sim/median_filter_3x3_test.sv =====
module median_filter_3x3_test;
    import mf3_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int LINE_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_PIXELS = 400;
    localparam int WIDE_TAIL     = 24;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [IDX_W-1:0] IDX_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0] IDX_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] median;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               done;
    } t_median_result;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx      = '0;
    logic [CFG_W-1:0]   i_cfg_data     = '0;
    logic               i_pixel_valid  = 1'b0;
    logic               o_pixel_ready;
    logic [FIELD_W-1:0] i_pixel        = '0;
    logic               o_result_valid;
    logic               i_result_ready = 1'b0;
    logic [FIELD_W-1:0] o_median_value;
    logic [COORD_W-1:0] o_center_col;
    logic [COORD_W-1:0] o_center_row;
    logic               o_frame_done;

    median_filter_3x3 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_median_value (o_median_value),
        .o_center_col   (o_center_col),
        .o_center_row   (o_center_row),
        .o_frame_done   (o_frame_done)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror of the filter: registers, line stores, window and raster position.
    logic [CFG_W-1:0]   cfg_width  = 11'd1024;
    logic [CFG_W-1:0]   cfg_height = 11'd1024;
    logic [FIELD_W-1:0] store_two_up [LINE_DEPTH];
    logic [FIELD_W-1:0] store_one_up [LINE_DEPTH];
    logic [FIELD_W-1:0] window [6] = '{default: '0};
    int                 next_col = 0;
    int                 next_row = 0;

    t_median_result     pending_medians [$];

    int  errors          = 0;
    int  pixels_sent     = 0;
    int  medians_checked = 0;
    int  frames_finished = 0;
    int  cfg_writes      = 0;

    // Sender and receiver pacing.
    bit  tx_offering  = 1'b0;
    bit  quiet_tx     = 1'b0;
    bit  quiet_rx     = 1'b0;
    bit  hold_request = 1'b0;
    int  burst_left   = 0;
    int  hold_left    = 0;
    int  run_left     = 0;
    int  stall_left   = 0;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic [FIELD_W-1:0] median_of_nine(input logic [8:0][FIELD_W-1:0] s);
        logic [8:0][FIELD_W-1:0] v;
        logic [FIELD_W-1:0]      t;
        v = s;
        for (int i = 0; i < 9; i++) begin
            for (int k = 0; k < 8 - i; k++) begin
                if (v[k] > v[k+1]) begin
                    t = v[k];
                    v[k] = v[k+1];
                    v[k+1] = t;
                end
            end
        end
        return v[4];
    endfunction

    task automatic predict_pixel(input logic [FIELD_W-1:0] pix);
        int                      w;
        int                      h;
        int                      c;
        int                      r;
        logic [FIELD_W-1:0]      top;
        logic [FIELD_W-1:0]      mid;
        logic [8:0][FIELD_W-1:0] nb;
        t_median_result          res;
        w = clamp_dim(cfg_width);
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = clamp_dim(cfg_height);
        // A resize can leave the position past the new frame edges.
        if (next_col >= w) begin
            next_col = 0;
            next_row++;
        end
        if (next_row >= h) next_row = 0;
        c = next_col;
        r = next_row;
        top = store_two_up[c];
        mid = store_one_up[c];
        store_two_up[c] = mid;
        store_one_up[c] = pix;
        if (r >= 2 && c >= 2) begin
            nb = {pix, window[5], window[2], mid, window[4], window[1],
                  top, window[3], window[0]};
            res.median = median_of_nine(nb);
            res.col    = COORD_W'(c - 1);
            res.row    = COORD_W'(r - 1);
            res.done   = (r == h - 1) && (c == w - 1);
            pending_medians.push_back(res);
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = pix;
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endtask

    function automatic bit at_frame_start();
        return next_col == 0 && next_row == 0;
    endfunction

    function automatic logic [FIELD_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return FIELD_W'($urandom_range(0, 3));
            default: return FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] edge_pattern(input int i);
        case (i % 8)
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hAAAA;
            3: return 16'h5555;
            4: return 16'h8000;
            5: return 16'h0001;
            6: return 16'h7FFF;
            default: return 16'hFFFE;
        endcase
    endfunction

    // Offers one pixel, waits for its transfer, then maybe opens a gap.
    task automatic send_pixel(input logic [FIELD_W-1:0] pix);
        int gap;
        i_pixel_valid <= 1'b1;
        i_pixel       <= pix;
        tx_offering = 1'b1;
        do @(posedge i_clk); while (!o_pixel_ready);
        predict_pixel(pix);
        pixels_sent++;
        if (!quiet_tx) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(0, 30);
                i_pixel_valid <= 1'b0;
                tx_offering = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering, lets every expected median out, then lets the pipe settle.
    task automatic wait_idle();
        if (tx_offering) begin
            i_pixel_valid <= 1'b0;
            tx_offering = 1'b0;
        end
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == IDX_IMAGE_WIDTH) cfg_width = data;
        else if (idx == IDX_IMAGE_HEIGHT) cfg_height = data;
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic finish_frame();
        do send_pixel(random_pixel()); while (!at_frame_start());
    endtask

    // Receiver: random runs and stalls, an always-ready mode and a long hold-off.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_result_ready <= 1'b0;
        end else if (quiet_rx) begin
            i_result_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_result_ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            i_result_ready <= 1'b1;
        end else begin
            run_left   = $urandom_range(0, 25);
            stall_left = $urandom_range(1, 6);
            i_result_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: median with none expected: value %0h at (%0d,%0d)",
                         $time, o_median_value, o_center_col, o_center_row);
                errors++;
            end else begin
                want = pending_medians.pop_front();
                medians_checked++;
                if (o_median_value !== want.median) begin
                    $display("%0t: median_value expected %0h, actual %0h",
                             $time, want.median, o_median_value);
                    errors++;
                end
                if (o_center_col !== want.col) begin
                    $display("%0t: center_col expected %0d, actual %0d",
                             $time, want.col, o_center_col);
                    errors++;
                end
                if (o_center_row !== want.row) begin
                    $display("%0t: center_row expected %0d, actual %0d",
                             $time, want.row, o_center_row);
                    errors++;
                end
                if (o_frame_done !== want.done) begin
                    $display("%0t: frame_done expected %0b, actual %0b",
                             $time, want.done, o_frame_done);
                    errors++;
                end
                if (want.done && o_frame_done === 1'b1) frames_finished++;
            end
        end
    end

    // Reset size is 1024 wide, so six pixels stay in row 0; shrinking the width
    // then pushes the next pixel into row 1.
    task automatic test_default_size_and_shrink();
        for (int i = 0; i < 6; i++) send_pixel(edge_pattern(i));
        wait_idle();
        write_reg(IDX_IMAGE_WIDTH, 11'd4);
        write_reg(IDX_IMAGE_HEIGHT, 11'd4);
        for (int i = 6; !(i > 6 && at_frame_start()); i++) send_pixel(edge_pattern(i * 3));
        wait_idle();
    endtask

    // Sizes below the minimum clamp to 3x3; writes to spare indexes change nothing.
    task automatic test_low_clamp();
        write_reg(IDX_SPARE_2, CFG_W'($urandom_range(0, 2047)));
        write_reg(IDX_SPARE_3, 11'h7FF);
        write_reg(IDX_IMAGE_WIDTH, 11'd0);
        write_reg(IDX_IMAGE_HEIGHT, 11'd2);
        for (int i = 0; i < 4; i++) send_pixel(16'hFFFF);
        send_pixel(16'h1234);
        for (int i = 0; i < 4; i++) send_pixel(16'h0000);
        wait_idle();
    endtask

    // One full row at the widest setting wraps the column counter; the width then
    // shrinks so the last row comes out quickly while the receiver holds off long
    // enough to back up the input.
    task automatic test_widest_rows();
        write_reg(IDX_IMAGE_WIDTH, 11'h7FF);
        write_reg(IDX_IMAGE_HEIGHT, 11'd1);
        quiet_tx = 1'b1;
        repeat (MAX_DIM + WIDE_TAIL) send_pixel(random_pixel());
        wait_idle();
        write_reg(IDX_IMAGE_WIDTH, CFG_W'(WIDE_TAIL));
        hold_request = 1'b1;
        finish_frame();
        quiet_tx = 1'b0;
        wait_idle();
    endtask

    // Tallest setting, cut short by a height change that wraps the row counter.
    task automatic test_tallest_then_wrap();
        write_reg(IDX_IMAGE_WIDTH, 11'd1);
        write_reg(IDX_IMAGE_HEIGHT, 11'h7FF);
        repeat (40 * MIN_DIM) send_pixel(random_pixel());
        wait_idle();
        write_reg(IDX_IMAGE_HEIGHT, 11'd5);
        finish_frame();
        wait_idle();
    endtask

    // Mostly small complete frames; some are broken off and resized mid-frame.
    // Mid-frame widths only shrink, so no line-store entry is read before it is written.
    task automatic test_random_frames();
        int start;
        int w;
        int h;
        int k;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 100) : $urandom_range(3, 24);
            h = $urandom_range(3, 10);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            write_reg(IDX_IMAGE_WIDTH, CFG_W'(w));
            write_reg(IDX_IMAGE_HEIGHT, CFG_W'(h));
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, w * h - 1);
                repeat (k) send_pixel(random_pixel());
                wait_idle();
                write_reg(IDX_IMAGE_WIDTH, CFG_W'($urandom_range(3, w)));
                write_reg(IDX_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 10)));
            end
            finish_frame();
            wait_idle();
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_default_size_and_shrink();
        test_low_clamp();
        test_widest_rows();
        test_tallest_then_wrap();
        test_random_frames();

        wait_idle();
        $display("Sent %0d pixels and checked %0d medians over %0d completed frames.",
                 pixels_sent, medians_checked, frames_finished);
        $display("Used %0d register writes: clamped sizes, mid-frame resizes, stalls.",
                 cfg_writes);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 2000000);
        $display("Timed out with %0d medians still expected.", pending_medians.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
